FILE: hdl/mbc_pkg.sv
// shared types and constants for the bank controller with real-time clock
package mbc_pkg;

    typedef enum logic [1:0] {
        FUNC_CTRL  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_TICK  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        RANGE_ENABLE = 2'd0,
        RANGE_ROM    = 2'd1,
        RANGE_SELECT = 2'd2,
        RANGE_LATCH  = 2'd3
    } range_t;

    localparam int CLK_REGS = 5;

    localparam logic [2:0] CLK_SEC   = 3'd0;
    localparam logic [2:0] CLK_MIN   = 3'd1;
    localparam logic [2:0] CLK_HOUR  = 3'd2;
    localparam logic [2:0] CLK_DAYL  = 3'd3;
    localparam logic [2:0] CLK_DAYH  = 3'd4;

    localparam logic [7:0] SEC_LIMIT   = 8'd60;
    localparam logic [7:0] HOUR_LIMIT  = 8'd24;
    localparam logic [7:0] DAYH_MASK   = 8'hC1;
    localparam logic [7:0] ROM_MASK    = 8'h7F;
    localparam logic [7:0] BANK_MAX    = 8'h03;
    localparam logic [7:0] CLK_SEL_LO  = 8'h08;
    localparam logic [7:0] CLK_SEL_HI  = 8'h0C;
    localparam logic [3:0] ENABLE_CODE = 4'hA;
    localparam int         HALT_BIT    = 6;
    localparam int         CARRY_BIT   = 7;

    localparam logic CFG_CLOCK_PRESENT = 1'b0;
    localparam logic CFG_RAM_PRESENT   = 1'b1;

    typedef struct packed {
        func_t       func;
        logic [14:0] addr;
        logic [7:0]  wdata;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        ram_strobe;
        logic [14:0] ram_address;
        logic [6:0]  rom_bank;
        logic        clock_mapped;
        logic        ram_on;
    } result_t;

endpackage

FILE: hdl/bank_controller_with_rtc.sv
// two registers from input transaction to result: the input register, then the result register
// throughput: one transaction per cycle while the output is not stalled; mbc_core updates its state as each one fires
// a stalled output holds one result while one more transaction waits in the input register
// reset: asynchronous active low; rom bank 1, ram bank 0, ram disabled,
// clock window unselected, live and latched clock zero, both presence bits set
module bank_controller_with_rtc
    import mbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [14:0] addr,
    input  logic [7:0]  wdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        ram_strobe,
    output logic [14:0] ram_address,
    output logic [6:0]  rom_bank,
    output logic        clock_mapped,
    output logic        ram_on,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    item_t   item_in;
    item_t   item_q;
    result_t res_comb;
    result_t res_q;
    logic    fire;
    logic    down_ready;

    assign item_in.func  = func_t'(func);
    assign item_in.addr  = addr;
    assign item_in.wdata = wdata;

    mbc_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .down_ready (down_ready),
        .fire       (fire),
        .item_q     (item_q)
    );

    mbc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item_q),
        .res       (res_comb)
    );

    mbc_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res_in    (res_comb),
        .up_ready  (down_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_q     (res_q)
    );

    assign read_data    = res_q.read_data;
    assign ram_strobe   = res_q.ram_strobe;
    assign ram_address  = res_q.ram_address;
    assign rom_bank     = res_q.rom_bank;
    assign clock_mapped = res_q.clock_mapped;
    assign ram_on       = res_q.ram_on;

endmodule

FILE: hdl/mbc_in_reg.sv
// input register stage holding one bus transaction
module mbc_in_reg
    import mbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t item_in,
    input  logic  down_ready,
    output logic  fire,
    output item_t item_q
);

    logic  valid_reg;
    item_t item_reg;

    assign fire     = valid_reg && down_ready;
    assign in_ready = !valid_reg || down_ready;
    assign item_q   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_in;
        end
    end

endmodule

FILE: hdl/mbc_core.sv
// bank registers, clock counters and per-transaction result logic
module mbc_core
    import mbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_we,
    input  logic    cfg_index,
    input  logic    cfg_data,
    input  logic    fire,
    input  item_t   item,
    output result_t res
);

    logic       clock_present_reg;
    logic       ram_present_reg;
    logic [6:0] rom_bank_reg,   rom_bank_next;
    logic [1:0] ram_bank_reg,   ram_bank_next;
    logic       ram_en_reg,     ram_en_next;
    logic       clk_sel_reg,    clk_sel_next;
    logic [2:0] clk_idx_reg,    clk_idx_next;
    logic       latch_bit_reg,  latch_bit_next;
    logic [7:0] live_reg    [CLK_REGS];
    logic [7:0] live_next   [CLK_REGS];
    logic [7:0] latched_reg [CLK_REGS];
    logic       do_latch;

    logic [2:0] idx;
    logic [7:0] sec_inc, min_inc, hour_inc;
    logic       sec_wrap, min_wrap, hour_wrap;
    logic [9:0] day_inc;
    logic [6:0] rom_sel;

    always_comb
    begin
        idx       = (clk_idx_reg > CLK_DAYH) ? CLK_DAYH : clk_idx_reg;
        sec_inc   = live_reg[CLK_SEC] + 8'd1;
        min_inc   = live_reg[CLK_MIN] + 8'd1;
        hour_inc  = live_reg[CLK_HOUR] + 8'd1;
        sec_wrap  = (sec_inc == SEC_LIMIT);
        min_wrap  = (min_inc == SEC_LIMIT);
        hour_wrap = (hour_inc == HOUR_LIMIT);
        day_inc   = {1'b0, live_reg[CLK_DAYH][0], live_reg[CLK_DAYL]} + 10'd1;
        rom_sel   = item.wdata[6:0] & ROM_MASK[6:0];

        rom_bank_next  = rom_bank_reg;
        ram_bank_next  = ram_bank_reg;
        ram_en_next    = ram_en_reg;
        clk_sel_next   = clk_sel_reg;
        clk_idx_next   = clk_idx_reg;
        latch_bit_next = latch_bit_reg;
        do_latch       = 1'b0;
        for (int i = 0; i < CLK_REGS; i++)
        begin
            live_next[i] = live_reg[i];
        end

        res.read_data   = 8'd0;
        res.ram_strobe  = 1'b0;
        res.ram_address = 15'd0;

        case (item.func)
            FUNC_CTRL:
            begin
                case (range_t'(item.addr[14:13]))
                    RANGE_ENABLE:
                    begin
                        if (ram_present_reg)
                        begin
                            ram_en_next = (item.wdata[3:0] == ENABLE_CODE);
                        end
                    end
                    RANGE_ROM:
                    begin
                        rom_bank_next = (rom_sel == 7'd0) ? 7'd1 : rom_sel;
                    end
                    RANGE_SELECT:
                    begin
                        if (item.wdata <= BANK_MAX)
                        begin
                            ram_bank_next = item.wdata[1:0];
                            clk_sel_next  = 1'b0;
                        end
                        else if (item.wdata inside {[CLK_SEL_LO:CLK_SEL_HI]}
                                 && clock_present_reg)
                        begin
                            clk_sel_next = 1'b1;
                            clk_idx_next = item.wdata[2:0] - CLK_SEL_LO[2:0];
                        end
                    end
                    RANGE_LATCH:
                    begin
                        if (clock_present_reg)
                        begin
                            do_latch       = !latch_bit_reg && item.wdata[0];
                            latch_bit_next = item.wdata[0];
                        end
                    end
                    default:
                    begin
                        rom_bank_next = rom_bank_reg;
                    end
                endcase
            end
            FUNC_TICK:
            begin
                if (!live_reg[CLK_DAYH][HALT_BIT])
                begin
                    live_next[CLK_SEC] = sec_wrap ? 8'd0 : sec_inc;
                    if (sec_wrap)
                    begin
                        live_next[CLK_MIN] = min_wrap ? 8'd0 : min_inc;
                    end
                    if (sec_wrap && min_wrap)
                    begin
                        live_next[CLK_HOUR] = hour_wrap ? 8'd0 : hour_inc;
                    end
                    // day count rolls over 511 into the carry flag
                    if (sec_wrap && min_wrap && hour_wrap)
                    begin
                        live_next[CLK_DAYL] = day_inc[7:0];
                        live_next[CLK_DAYH] = {live_reg[CLK_DAYH][CARRY_BIT] | day_inc[9],
                                               live_reg[CLK_DAYH][6:1], day_inc[8]};
                    end
                end
            end
            default:
            begin
                if (ram_en_reg)
                begin
                    if (clk_sel_reg)
                    begin
                        if (item.func == FUNC_READ)
                        begin
                            res.read_data = latched_reg[idx];
                        end
                        else if (idx == CLK_DAYH)
                        begin
                            live_next[CLK_DAYH] = item.wdata & DAYH_MASK;
                        end
                        else
                        begin
                            live_next[idx] = item.wdata;
                        end
                    end
                    else
                    begin
                        res.ram_strobe  = 1'b1;
                        res.ram_address = {ram_bank_reg, item.addr[12:0]};
                    end
                end
            end
        endcase

        res.rom_bank     = rom_bank_next;
        res.clock_mapped = clk_sel_next;
        res.ram_on       = ram_en_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_present_reg <= 1'b1;
            ram_present_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_CLOCK_PRESENT)
            begin
                clock_present_reg <= cfg_data;
            end
            else
            begin
                ram_present_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg  <= 7'd1;
            ram_bank_reg  <= 2'd0;
            ram_en_reg    <= 1'b0;
            clk_sel_reg   <= 1'b0;
            clk_idx_reg   <= 3'd0;
            latch_bit_reg <= 1'b0;
            for (int i = 0; i < CLK_REGS; i++)
            begin
                live_reg[i]    <= 8'd0;
                latched_reg[i] <= 8'd0;
            end
        end
        else if (fire)
        begin
            rom_bank_reg  <= rom_bank_next;
            ram_bank_reg  <= ram_bank_next;
            ram_en_reg    <= ram_en_next;
            clk_sel_reg   <= clk_sel_next;
            clk_idx_reg   <= clk_idx_next;
            latch_bit_reg <= latch_bit_next;
            for (int i = 0; i < CLK_REGS; i++)
            begin
                live_reg[i] <= live_next[i];
                if (do_latch)
                begin
                    latched_reg[i] <= live_reg[i];
                end
            end
        end
    end

endmodule

FILE: hdl/mbc_out_reg.sv
// result register towards the output channel
module mbc_out_reg
    import mbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  result_t res_in,
    output logic    up_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res_q
);

    logic    valid_reg;
    result_t res_reg;

    assign up_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_q     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_in;
        end
    end

endmodule

FILE: hdl/mbc_checker.sv
// port-level checks for the bank controller, bound to the top level
module mbc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  read_data,
    input logic        ram_strobe,
    input logic [14:0] ram_address,
    input logic [6:0]  rom_bank,
    input logic        clock_mapped,
    input logic        ram_on
);

    // bank zero is always remapped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rom_bank != 7'd0)
        else $error("rom bank reads zero");

    // ram is only strobed when enabled and not mapping a clock register
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ram_strobe |-> ram_on && !clock_mapped)
        else $error("ram strobe while disabled or clock mapped");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ram_strobe |-> ram_address == 15'd0)
        else $error("ram address without strobe");

    // only a clock read returns data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_data != 8'd0 |-> clock_mapped && ram_on && !ram_strobe)
        else $error("read data outside a clock read");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rom_bank) && $stable(read_data))
        else $error("stalled transaction changed");

endmodule

bind bank_controller_with_rtc mbc_checker u_mbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .ram_strobe   (ram_strobe),
    .ram_address  (ram_address),
    .rom_bank     (rom_bank),
    .clock_mapped (clock_mapped),
    .ram_on       (ram_on)
);

FILE: test/tb_bank_controller_with_rtc.sv
// self-checking testbench for the bank controller with real-time clock
module tb_bank_controller_with_rtc;
    timeunit 1ns;
    timeprecision 1ps;
    import mbc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 6;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [1:0]  func         = '0;
    logic [14:0] addr         = '0;
    logic [7:0]  wdata        = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [7:0]  read_data;
    logic        ram_strobe;
    logic [14:0] ram_address;
    logic [6:0]  rom_bank;
    logic        clock_mapped;
    logic        ram_on;
    logic        cfg_we       = 1'b0;
    logic        cfg_index    = 1'b0;
    logic        cfg_data     = 1'b0;

    // shadow copy of the controller state
    logic [6:0]  rom_bank_m;
    logic [1:0]  ram_bank_m;
    logic        ram_en_m;
    logic        clk_sel_m;
    logic [2:0]  clk_idx_m;
    logic        latch_m;
    logic [7:0]  live_m [CLK_REGS];
    logic [7:0]  latched_m [CLK_REGS];
    logic        have_clock_m;
    logic        have_ram_m;

    item_t       bus_queue [$];
    result_t     results_due [$];
    logic        in_taken     = 1'b0;
    logic        holding      = 1'b0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          phase_no     = 0;
    int          mismatches   = 0;
    int          n_checked    = 0;
    int          n_strobes    = 0;
    int          n_clock_reads = 0;
    int          cycle_count  = 0;

    bank_controller_with_rtc i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .addr         (addr),
        .wdata        (wdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .ram_strobe   (ram_strobe),
        .ram_address  (ram_address),
        .rom_bank     (rom_bank),
        .clock_mapped (clock_mapped),
        .ram_on       (ram_on),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // applies one bus event to the shadow state and returns what the block should report
    function automatic result_t next_bus_result(item_t it);
        result_t    r;
        logic [9:0] days;
        r = '0;
        case (it.func)
            FUNC_CTRL:
            begin
                case (range_t'(it.addr[14:13]))
                    RANGE_ENABLE:
                    begin
                        if (have_ram_m)
                            ram_en_m = (it.wdata[3:0] == ENABLE_CODE);
                    end
                    RANGE_ROM:
                    begin
                        rom_bank_m = 7'(it.wdata & ROM_MASK);
                        if (rom_bank_m == 7'd0)
                            rom_bank_m = 7'd1;
                    end
                    RANGE_SELECT:
                    begin
                        if (it.wdata <= BANK_MAX)
                        begin
                            ram_bank_m = it.wdata[1:0];
                            clk_sel_m  = 1'b0;
                        end
                        else if (it.wdata >= CLK_SEL_LO && it.wdata <= CLK_SEL_HI
                                 && have_clock_m)
                        begin
                            clk_sel_m = 1'b1;
                            clk_idx_m = 3'(it.wdata - CLK_SEL_LO);
                        end
                    end
                    default:
                    begin
                        if (have_clock_m)
                        begin
                            if (!latch_m && it.wdata[0])
                                latched_m = live_m;
                            latch_m = it.wdata[0];
                        end
                    end
                endcase
            end
            FUNC_TICK:
            begin
                // counters carry only on hitting their limit exactly
                if (!live_m[CLK_DAYH][HALT_BIT])
                begin
                    live_m[CLK_SEC] = live_m[CLK_SEC] + 8'd1;
                    if (live_m[CLK_SEC] == SEC_LIMIT)
                    begin
                        live_m[CLK_SEC] = 8'd0;
                        live_m[CLK_MIN] = live_m[CLK_MIN] + 8'd1;
                        if (live_m[CLK_MIN] == SEC_LIMIT)
                        begin
                            live_m[CLK_MIN]  = 8'd0;
                            live_m[CLK_HOUR] = live_m[CLK_HOUR] + 8'd1;
                            if (live_m[CLK_HOUR] == HOUR_LIMIT)
                            begin
                                live_m[CLK_HOUR] = 8'd0;
                                days = {1'b0, live_m[CLK_DAYH][0], live_m[CLK_DAYL]} + 10'd1;
                                if (days[9])
                                    live_m[CLK_DAYH][CARRY_BIT] = 1'b1;
                                live_m[CLK_DAYL]    = days[7:0];
                                live_m[CLK_DAYH][0] = days[8];
                            end
                        end
                    end
                end
            end
            default:
            begin
                if (ram_en_m)
                begin
                    if (!clk_sel_m)
                    begin
                        r.ram_strobe  = 1'b1;
                        r.ram_address = {ram_bank_m, it.addr[12:0]};
                    end
                    else if (it.func == FUNC_READ)
                        r.read_data = latched_m[clk_idx_m];
                    else if (clk_idx_m == CLK_DAYH)
                        live_m[CLK_DAYH] = it.wdata & DAYH_MASK;
                    else
                        live_m[clk_idx_m] = it.wdata;
                end
            end
        endcase
        r.rom_bank     = rom_bank_m;
        r.clock_mapped = clk_sel_m;
        r.ram_on       = ram_en_m;
        return r;
    endfunction

    function automatic void check_field(string name, logic [14:0] want, logic [14:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // compare finished transactions first, then predict the one taken at this edge
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        item_t   it;
        in_taken <= in_valid && in_ready;
        if (out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result transaction with nothing outstanding");
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("read_data", 15'(want.read_data), 15'(read_data));
                check_field("ram_strobe", 15'(want.ram_strobe), 15'(ram_strobe));
                check_field("ram_address", want.ram_address, ram_address);
                check_field("rom_bank", 15'(want.rom_bank), 15'(rom_bank));
                check_field("clock_mapped", 15'(want.clock_mapped), 15'(clock_mapped));
                check_field("ram_on", 15'(want.ram_on), 15'(ram_on));
                n_checked++;
            end
        end
        if (in_valid && in_ready)
        begin
            it.func  = func_t'(func);
            it.addr  = addr;
            it.wdata = wdata;
            want = next_bus_result(it);
            if (want.ram_strobe)
                n_strobes++;
            if (it.func == FUNC_READ && want.ram_on && want.clock_mapped)
                n_clock_reads++;
            results_due.push_back(want);
        end
    end

    always @(negedge clk)
    begin : driver
        item_t nxt;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (bus_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = bus_queue.pop_front();
                func     <= nxt.func;
                addr     <= nxt.addr;
                wdata    <= nxt.wdata;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_ready <= rst_n && !holding && ($urandom_range(99) >= recv_stall_pct);

    // long receiver hold-off early in the first unthrottled phase
    initial
    begin
        wait (phase_no == 1);
        repeat (30) @(posedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_bus(input func_t f, input logic [14:0] a, input logic [7:0] d);
        item_t it;
        it.func  = f;
        it.addr  = a;
        it.wdata = d;
        bus_queue.push_back(it);
    endtask

    task automatic wait_idle();
        while (bus_queue.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_CLOCK_PRESENT)
            have_clock_m = val;
        else
            have_ram_m = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int idle, input int stall,
                             input logic clock_cfg, input logic ram_cfg);
        item_t it;
        int    pick;
        wait_idle();
        write_cfg(CFG_CLOCK_PRESENT, clock_cfg);
        write_cfg(CFG_RAM_PRESENT, ram_cfg);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        phase_no++;
        repeat (count)
        begin
            pick     = $urandom_range(99);
            it.func  = FUNC_CTRL;
            it.addr  = 15'($urandom);
            it.wdata = 8'($urandom);
            if (pick < 8)
            begin
                it.addr[14:13] = RANGE_ENABLE;
                if ($urandom_range(4) != 0)
                    it.wdata[3:0] = ENABLE_CODE;
            end
            else if (pick < 16)
                it.addr[14:13] = RANGE_ROM;
            else if (pick < 30)
            begin
                it.addr[14:13] = RANGE_SELECT;
                if (pick < 21)
                    it.wdata = 8'($urandom_range(3));
                else if (pick < 27)
                    it.wdata = 8'($urandom_range(CLK_SEL_HI, CLK_SEL_LO));
            end
            else if (pick < 40)
                it.addr[14:13] = RANGE_LATCH;
            else if (pick < 55)
                it.func = FUNC_READ;
            else if (pick < 72)
            begin
                it.func = FUNC_WRITE;
                // values close to the counter limits so that carries happen
                if ($urandom_range(1) != 0)
                begin
                    case ($urandom_range(3))
                        0:       it.wdata = SEC_LIMIT - 8'($urandom_range(2));
                        1:       it.wdata = HOUR_LIMIT - 8'($urandom_range(2));
                        2:       it.wdata = 8'hFF - 8'($urandom_range(1));
                        default: it.wdata = 8'($urandom) & 8'hBF;
                    endcase
                end
            end
            else
                it.func = FUNC_TICK;
            bus_queue.push_back(it);
        end
    endtask

    initial
    begin : sequencer
        rom_bank_m   = 7'd1;
        ram_bank_m   = 2'd0;
        ram_en_m     = 1'b0;
        clk_sel_m    = 1'b0;
        clk_idx_m    = CLK_SEC;
        latch_m      = 1'b0;
        have_clock_m = 1'b1;
        have_ram_m   = 1'b1;
        for (int i = 0; i < CLK_REGS; i++)
        begin
            live_m[i]    = 8'd0;
            latched_m[i] = 8'd0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // accesses while disabled, then enable with junk in the high nibble
        queue_bus(FUNC_READ,  15'h7FFF, 8'hFF);
        queue_bus(FUNC_WRITE, 15'h1234, 8'h55);
        queue_bus(FUNC_CTRL,  15'h1FFF, 8'hFA);
        // rom bank zero maps to one, upper bit dropped
        queue_bus(FUNC_CTRL,  15'h2000, 8'h00);
        queue_bus(FUNC_CTRL,  15'h3FFF, 8'hFF);
        queue_bus(FUNC_CTRL,  15'h2000, 8'h80);
        queue_bus(FUNC_CTRL,  15'h4000, 8'h03);
        queue_bus(FUNC_WRITE, 15'h7FFF, 8'hA5);
        // bank selects that must be ignored
        queue_bus(FUNC_CTRL,  15'h5FFF, 8'h07);
        queue_bus(FUNC_CTRL,  15'h4000, 8'h0D);
        queue_bus(FUNC_CTRL,  15'h4000, 8'hFF);
        // day high masked write halts the clock
        queue_bus(FUNC_CTRL,  15'h4000, 8'h0C);
        queue_bus(FUNC_WRITE, 15'h0000, 8'hFF);
        queue_bus(FUNC_TICK,  15'h0000, 8'h00);
        // preset to the last second of day 511, then roll over into the carry
        queue_bus(FUNC_WRITE, 15'h0000, 8'h01);
        queue_bus(FUNC_CTRL,  15'h4000, 8'h0B);
        queue_bus(FUNC_WRITE, 15'h0000, 8'hFF);
        queue_bus(FUNC_CTRL,  15'h4000, 8'h0A);
        queue_bus(FUNC_WRITE, 15'h0000, 8'd23);
        queue_bus(FUNC_CTRL,  15'h4000, 8'h09);
        queue_bus(FUNC_WRITE, 15'h0000, 8'd59);
        queue_bus(FUNC_CTRL,  15'h4000, 8'h08);
        queue_bus(FUNC_WRITE, 15'h0000, 8'd59);
        queue_bus(FUNC_TICK,  15'h0000, 8'h00);
        queue_bus(FUNC_CTRL,  15'h6000, 8'h01);
        queue_bus(FUNC_CTRL,  15'h4000, 8'h0C);
        queue_bus(FUNC_READ,  15'h0000, 8'h00);
        // seconds beyond their limit wrap at eight bits without carrying
        queue_bus(FUNC_CTRL,  15'h4000, 8'h08);
        queue_bus(FUNC_WRITE, 15'h0000, 8'hFF);
        queue_bus(FUNC_TICK,  15'h0000, 8'h00);
        queue_bus(FUNC_CTRL,  15'h0000, 8'h0B);

        run_phase(170, 0,  0,  1'b1, 1'b1);
        run_phase(140, 54, 0,  1'b0, 1'b1);
        run_phase(140, 0,  54, 1'b1, 1'b0);
        run_phase(140, 32, 32, 1'b0, 1'b0);
        run_phase(160, 32, 32, 1'b1, 1'b1);
        wait_idle();

        $display("checked %0d bus transactions: %0d ram strobes, %0d clock register reads",
                 n_checked, n_strobes, n_clock_reads);
        $display("five configuration phases, every idling mix, one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/mbc_pkg.sv
hdl/mbc_in_reg.sv
hdl/mbc_core.sv
hdl/mbc_out_reg.sv
hdl/bank_controller_with_rtc.sv
hdl/mbc_checker.sv
test/tb_bank_controller_with_rtc.sv
